// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int VALUE_W  = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL_DROP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd2;

  typedef struct packed {
    logic                       push;
    logic                       pop;
    logic signed [VALUE_W-1:0]  value;
  } spq_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  spq_ctrl_t                 ctrl,
  input  logic                      valid,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] right_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic signed [VALUE_W-1:0] entry_next,
  output logic                      gt
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;

  assign gt = valid && (entry_r > ctrl.value);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.push) begin
      if (gt) begin
        entry_nxt = entry_r;
      end else if (left_gt) begin
        entry_nxt = ctrl.value;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry      = entry_r;
  assign entry_next = entry_nxt;

endmodule

// ===== design/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Results are registered; out_tvalid is set in the cycle after an input is accepted.
// Throughput: one transaction per cycle while out_tready is high; every chain cell
// compares and shifts in the same cycle; the output register refills as it drains.
// Reset: synchronous, active low; clears the entry count and the output valid flag.
// The entry storage itself is not cleared and is only read below the count.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] top_value, [8] queue_empty,
                                  // [13:9] entry_count, [15:14] status
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic [15:0]      out_data_nxt;

  logic             accept;
  logic             is_push;
  logic             full;
  logic             empty;
  logic [STATUS_W-1:0] status;
  spq_ctrl_t        ctrl;

  logic signed [VALUE_W-1:0] entry     [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] entry_nx  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    gt;
  logic [QUEUE_DEPTH-1:0]    valid;
  logic [CNT_W+COUNT_W-1:0]  count_ext;
  logic signed [VALUE_W-1:0] top;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_push   = (in_tuser[0] == CMD_PUSH);
  assign full      = (count_r >= DEPTH_C);
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.value = in_tdata;
    ctrl.push  = accept && is_push && !full;
    ctrl.pop   = accept && !is_push && !empty;
  end

  always_comb begin
    count_nxt = count_r;
    status    = STATUS_DONE;
    if (is_push) begin
      if (full) begin
        status = STATUS_FULL_DROP;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status = STATUS_POP_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign valid[i] = (CNT_W'(i) < count_r);
      if (i == 0) begin : g_first
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .valid       (valid[i]),
          .left_entry  (ctrl.value),
          .left_gt     (1'b1),
          .right_entry (entry[(QUEUE_DEPTH > 1) ? 1 : 0]),
          .entry       (entry[i]),
          .entry_next  (entry_nx[i]),
          .gt          (gt[i])
        );
      end else if (i == QUEUE_DEPTH - 1) begin : g_last
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .valid       (valid[i]),
          .left_entry  (entry[i-1]),
          .left_gt     (gt[i-1]),
          .right_entry (entry[i]),
          .entry       (entry[i]),
          .entry_next  (entry_nx[i]),
          .gt          (gt[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .valid       (valid[i]),
          .left_entry  (entry[i-1]),
          .left_gt     (gt[i-1]),
          .right_entry (entry[i+1]),
          .entry       (entry[i]),
          .entry_next  (entry_nx[i]),
          .gt          (gt[i])
        );
      end
    end
  endgenerate

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};
  assign top       = (count_nxt == '0) ? '0 : entry_nx[0];

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[7:0]   = top;
    out_data_nxt[8]     = (count_nxt == '0);
    out_data_nxt[13:9]  = count_ext[COUNT_W-1:0];
    out_data_nxt[15:14] = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
